// ===== rtl/core/utf8_sentence_chunk_splitter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chunk splitter
// Shared property templates, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef UTF8_SENTENCE_CHUNK_SPLITTER_UNIT_DEFINES_SVH
`define UTF8_SENTENCE_CHUNK_SPLITTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8CS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8CS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/u8cs_pkg.sv =====
// ----------------------------------------------------------------------------
// u8cs_pkg
// Constants, types and byte classifiers of the UTF-8 chunk splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package u8cs_pkg;

  localparam int STORE_DEPTH_DEF  = 1024;
  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int POS_W            = 64;
  localparam int OUT_W            = 32;
  localparam int LIMIT_W          = 10;
  localparam int LOOKAHEAD        = 5;
  localparam int HIST_DEPTH       = 8;
  localparam int QUEUE_DEPTH      = 4;
  localparam int PADDR_W          = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 10'd256;
  localparam logic               REG_MAX_CHUNK = 1'b0;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EXCL  = 8'h21;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] MASK_C0 = 8'hC0;
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] MASK_F8 = 8'hF8;
  localparam logic [7:0] CONT_80 = 8'h80;

  typedef enum logic [2:0] {
    F_IDLE, F_SCAN, F_WALK, F_WALK_WAIT, F_CUT, F_FLUSH, F_END
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LO, B_LO_WAIT, B_HI, B_HI_WAIT, B_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c & MASK_C0) == CONT_80;
  endfunction

  function automatic logic is_hard1(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_DOT) || (c == CH_QUEST) || (c == CH_EXCL);
  endfunction

  function automatic logic is_soft1(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON);
  endfunction

  // Ideographic full stop, full-width question mark, full-width exclamation.
  function automatic logic is_hard3(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2);
    return ((b0 == 8'hE3) && (b1 == 8'h80) && (b2 == 8'h82)) ||
           ((b0 == 8'hEF) && (b1 == 8'hBC) && (b2 == 8'h9F)) ||
           ((b0 == 8'hEF) && (b1 == 8'hBC) && (b2 == 8'h81));
  endfunction

  // Ideographic comma, full-width semicolon.
  function automatic logic is_soft3(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2);
    return ((b0 == 8'hE3) && (b1 == 8'h80) && (b2 == 8'h81)) ||
           ((b0 == 8'hEF) && (b1 == 8'hBC) && (b2 == 8'h9B));
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    if ((b & CONT_80) == 8'h00)         n = 3'd1;
    else if ((b & MASK_E0) == MASK_C0)  n = 3'd2;
    else if ((b & MASK_F0) == MASK_E0)  n = 3'd3;
    else if ((b & MASK_F8) == MASK_F0)  n = 3'd4;
    else                                n = 3'd1;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u8cs_store.sv =====
// ----------------------------------------------------------------------------
// u8cs_store
// Chunk byte store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cs_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_a_addr,
  output logic [7:0]         rd_a_data,
  input  wire logic [AW-1:0] rd_b_addr,
  output logic [7:0]         rd_b_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8cs_fifo.sv =====
// ----------------------------------------------------------------------------
// u8cs_fifo
// Short queue of chunk requests between the scanner and the trimmer.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output u8cs_pkg::q_status_t   status
);
  import u8cs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8cs_front.sv =====
// ----------------------------------------------------------------------------
// u8cs_front
// Takes text bytes, scans characters and queues raw chunk boundaries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_sentence_chunk_splitter_unit_defines.svh"

module u8cs_front #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int PW    = 64,
  parameter int EW    = 149
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_fin,
  input  wire logic [u8cs_pkg::LIMIT_W-1:0]   limit_reg,
  input  wire logic                           back_idle,
  input  wire u8cs_pkg::q_status_t            q_status,
  output logic                                push,
  output logic [EW-1:0]                       push_data,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [7:0]                          wr_data,
  output logic [AW-1:0]                       rd_addr,
  input  wire logic [7:0]                     rd_data
);
  import u8cs_pkg::*;

  function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [2:0] n);
    logic [AW:0] s;
    s = {1'b0, a} + {{(AW-2){1'b0}}, n};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  front_state_t state, state_next;

  logic [PW-1:0] pos, pos_next;
  logic [AW-1:0] pos_addr, pos_addr_next;
  logic [PW-1:0] scan, scan_next;
  logic [AW-1:0] scan_addr, scan_addr_next;
  logic [PW-1:0] start, start_next;
  logic [AW-1:0] start_addr, start_addr_next;
  logic [PW-1:0] soft_pos, soft_pos_next;
  logic [AW-1:0] soft_addr, soft_addr_next;
  logic [PW-1:0] cut, cut_next;
  logic [AW-1:0] cut_addr, cut_addr_next;
  logic [PW-1:0] ni_r, ni_r_next;
  logic [AW-1:0] ni_addr_r, ni_addr_r_next;
  logic          fin_r, fin_r_next;
  logic [7:0]    hist [HIST_DEPTH];

  logic [PW-1:0]      remain;
  logic               can_scan;
  logic [2:0]         d;
  logic [7:0]         b0, b1, b2;
  logic               has3;
  logic               hard, soft_hit;
  logic [2:0]         step_n;
  logic [PW-1:0]      ni;
  logic [AW-1:0]      ni_addr;
  logic [LIMIT_W-1:0] lim;
  logic               over;
  logic               accept;

  // Unscanned bytes are always among the newest ones, so the scan step reads
  // them from the history register rather than from the store.
  assign remain   = pos - scan;
  assign can_scan = (scan < pos) && (fin_r || (remain >= PW'(LOOKAHEAD)));
  assign d        = remain[2:0] - 3'd1;
  assign b0       = hist[d];
  assign b1       = hist[d - 3'd1];
  assign b2       = hist[d - 3'd2];
  assign has3     = (d >= 3'd2);
  assign hard     = is_hard1(b0) || (has3 && is_hard3(b0, b1, b2));
  assign soft_hit = is_soft1(b0) || (has3 && is_soft3(b0, b1, b2));

  always_comb begin
    priority if (is_hard1(b0) || is_soft1(b0)) step_n = 3'd1;
    else if (hard || soft_hit)                 step_n = 3'd3;
    else                                       step_n = lead_len(b0);
  end

  assign ni      = scan + PW'(step_n);
  assign ni_addr = addr_add(scan_addr, step_n);
  assign lim     = (limit_reg == '0) ? LIMIT_DEFAULT : limit_reg;
  assign over    = (ni - start) >= PW'(lim);

  assign accept   = in_valid && in_ready;
  assign wr_en    = accept;
  assign wr_addr  = pos_addr;
  assign wr_data  = in_byte;
  assign rd_addr  = cut_addr;

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    pos_addr_next   = pos_addr;
    scan_next       = scan;
    scan_addr_next  = scan_addr;
    start_next      = start;
    start_addr_next = start_addr;
    soft_pos_next   = soft_pos;
    soft_addr_next  = soft_addr;
    cut_next        = cut;
    cut_addr_next   = cut_addr;
    ni_r_next       = ni_r;
    ni_addr_r_next  = ni_addr_r;
    fin_r_next      = fin_r;
    in_ready        = 1'b0;
    push            = 1'b0;
    push_data       = {1'b0, start, ni, start_addr, ni_addr};

    unique case (state)
      F_IDLE: begin
        in_ready = back_idle;
        if (accept) begin
          pos_next      = pos + PW'(1);
          pos_addr_next = addr_add(pos_addr, 3'd1);
          fin_r_next    = in_fin;
          state_next    = F_SCAN;
        end
      end
      F_SCAN: begin
        if (!can_scan) begin
          state_next = fin_r ? F_FLUSH : F_END;
        end else if (!q_status.full) begin
          scan_next      = ni;
          scan_addr_next = ni_addr;
          priority if (hard) begin
            push            = 1'b1;
            start_next      = ni;
            start_addr_next = ni_addr;
            soft_pos_next   = '0;
          end else if (soft_hit) begin
            if (over) begin
              push            = 1'b1;
              start_next      = ni;
              start_addr_next = ni_addr;
              soft_pos_next   = '0;
            end else begin
              soft_pos_next  = ni;
              soft_addr_next = ni_addr;
            end
          end else if (over) begin
            // Forced cut: at the last soft separator if one lies in the chunk.
            if (soft_pos > start) begin
              cut_next      = soft_pos;
              cut_addr_next = soft_addr;
            end else begin
              cut_next      = ni;
              cut_addr_next = ni_addr;
            end
            ni_r_next      = ni;
            ni_addr_r_next = ni_addr;
            state_next     = F_WALK;
          end
        end
      end
      F_WALK: begin
        state_next = ((cut > start) && (cut < pos)) ? F_WALK_WAIT : F_CUT;
      end
      F_WALK_WAIT: begin
        if (is_cont(rd_data)) begin
          cut_next      = cut - PW'(1);
          cut_addr_next = addr_dec(cut_addr);
          state_next    = F_WALK;
        end else begin
          state_next = F_CUT;
        end
      end
      F_CUT: begin
        if (!q_status.full) begin
          push = 1'b1;
          if (cut <= start) begin
            push_data       = {1'b0, start, ni_r, start_addr, ni_addr_r};
            start_next      = ni_r;
            start_addr_next = ni_addr_r;
          end else begin
            push_data       = {1'b0, start, cut, start_addr, cut_addr};
            start_next      = cut;
            start_addr_next = cut_addr;
          end
          soft_pos_next = '0;
          state_next    = F_SCAN;
        end
      end
      F_FLUSH: begin
        push_data = {1'b0, start, pos, start_addr, pos_addr};
        if (start < pos) begin
          if (!q_status.full) begin
            push       = 1'b1;
            state_next = F_END;
          end
        end else begin
          state_next = F_END;
        end
      end
      F_END: begin
        push_data = {1'b1, start, pos, start_addr, pos_addr};
        if (!q_status.full) begin
          push       = 1'b1;
          state_next = F_IDLE;
          if (fin_r) begin
            pos_next        = '0;
            pos_addr_next   = '0;
            scan_next       = '0;
            scan_addr_next  = '0;
            start_next      = '0;
            start_addr_next = '0;
            soft_pos_next   = '0;
            soft_addr_next  = '0;
            fin_r_next      = 1'b0;
          end
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      pos        <= '0;
      pos_addr   <= '0;
      scan       <= '0;
      scan_addr  <= '0;
      start      <= '0;
      start_addr <= '0;
      soft_pos   <= '0;
      soft_addr  <= '0;
      fin_r      <= 1'b0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      pos_addr   <= pos_addr_next;
      scan       <= scan_next;
      scan_addr  <= scan_addr_next;
      start      <= start_next;
      start_addr <= start_addr_next;
      soft_pos   <= soft_pos_next;
      soft_addr  <= soft_addr_next;
      fin_r      <= fin_r_next;
    end
  end

  always_ff @(posedge clk) begin
    cut       <= cut_next;
    cut_addr  <= cut_addr_next;
    ni_r      <= ni_r_next;
    ni_addr_r <= ni_addr_r_next;
    if (accept) begin
      hist[0] <= in_byte;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  `U8CS_ASSERT_IMP(a_lookahead_bound, state == F_IDLE, remain < PW'(LOOKAHEAD), "lookahead overrun")
  `U8CS_ASSERT_IMP(a_start_behind_scan, state == F_SCAN, start <= scan, "chunk start ahead of scan")
  `U8CS_ASSERT_IMP(a_push_room, push, !q_status.full, "push into a full queue")

endmodule

`default_nettype wire

// ===== rtl/core/u8cs_back.sv =====
// ----------------------------------------------------------------------------
// u8cs_back
// Trims queued chunks, drops empty ones and marks the last word of a run.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_sentence_chunk_splitter_unit_defines.svh"

module u8cs_back #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int PW    = 64,
  parameter int OW    = 32,
  parameter int EW    = 149
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire u8cs_pkg::q_status_t          q_status,
  output logic                              pop,
  input  wire logic [EW-1:0]                pop_data,
  output logic [AW-1:0]                     rd_addr,
  input  wire logic [7:0]                   rd_data,
  output logic                              idle,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [u8cs_pkg::OUT_W-1:0]        out_first,
  output logic [u8cs_pkg::OUT_W-1:0]        out_end,
  output logic                              out_last
);
  import u8cs_pkg::*;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  // Offsets clamp at the largest value of the offset width, then keep 32 bits.
  function automatic logic [OUT_W-1:0] sat(input logic [PW-1:0] v);
    logic [PW-1:0] sat_max;
    sat_max = (OW >= PW) ? '1 : ((PW'(1) << OW) - PW'(1));
    return OUT_W'((v > sat_max) ? sat_max : v);
  endfunction

  back_state_t state, state_next;

  logic             q_mark;
  logic [PW-1:0]    q_lo, q_hi;
  logic [AW-1:0]    q_lo_addr, q_hi_addr;

  logic [PW-1:0]    lo, lo_next, hi, hi_next;
  logic [AW-1:0]    lo_addr, lo_addr_next, hi_addr, hi_addr_next;
  logic             pend_valid, pend_valid_next;
  logic [OUT_W-1:0] pend_first, pend_first_next, pend_end, pend_end_next;
  logic             out_valid_next, out_last_next;
  logic [OUT_W-1:0] out_first_next, out_end_next;
  logic             out_free;

  assign {q_mark, q_lo, q_hi, q_lo_addr, q_hi_addr} = pop_data;
  assign out_free = !out_valid || out_ready;
  assign idle     = (state == B_IDLE);
  assign rd_addr  = (state == B_LO) ? lo_addr : addr_dec(hi_addr);

  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    lo_addr_next    = lo_addr;
    hi_addr_next    = hi_addr;
    pend_valid_next = pend_valid;
    pend_first_next = pend_first;
    pend_end_next   = pend_end;
    out_valid_next  = out_valid && !out_ready;
    out_first_next  = out_first;
    out_end_next    = out_end;
    out_last_next   = out_last;
    pop             = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          if (q_mark) begin
            // End of run: the held word goes out flagged as last.
            if (!pend_valid) begin
              pop = 1'b1;
            end else if (out_free) begin
              pop             = 1'b1;
              out_valid_next  = 1'b1;
              out_first_next  = pend_first;
              out_end_next    = pend_end;
              out_last_next   = 1'b1;
              pend_valid_next = 1'b0;
            end
          end else begin
            pop          = 1'b1;
            lo_next      = q_lo;
            hi_next      = q_hi;
            lo_addr_next = q_lo_addr;
            hi_addr_next = q_hi_addr;
            state_next   = B_LO;
          end
        end
      end
      B_LO: begin
        state_next = (lo < hi) ? B_LO_WAIT : B_HI;
      end
      B_LO_WAIT: begin
        if (is_space(rd_data)) begin
          lo_next      = lo + PW'(1);
          lo_addr_next = addr_inc(lo_addr);
          state_next   = B_LO;
        end else begin
          state_next = B_HI;
        end
      end
      B_HI: begin
        state_next = (hi > lo) ? B_HI_WAIT : B_DONE;
      end
      B_HI_WAIT: begin
        if (is_space(rd_data)) begin
          hi_next      = hi - PW'(1);
          hi_addr_next = addr_dec(hi_addr);
          state_next   = B_HI;
        end else begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (lo < hi) begin
          if (!pend_valid) begin
            pend_valid_next = 1'b1;
            pend_first_next = sat(lo);
            pend_end_next   = sat(hi);
            state_next      = B_IDLE;
          end else if (out_free) begin
            out_valid_next  = 1'b1;
            out_first_next  = pend_first;
            out_end_next    = pend_end;
            out_last_next   = 1'b0;
            pend_first_next = sat(lo);
            pend_end_next   = sat(hi);
            state_next      = B_IDLE;
          end
        end else begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    lo_addr    <= lo_addr_next;
    hi_addr    <= hi_addr_next;
    pend_first <= pend_first_next;
    pend_end   <= pend_end_next;
    out_first  <= out_first_next;
    out_end    <= out_end_next;
    out_last   <= out_last_next;
  end

  `U8CS_ASSERT_IMP(a_out_order, out_valid, out_first <= out_end, "chunk ends before it starts")
  `U8CS_ASSERT_NXT(a_run_close, (state == B_IDLE) && !q_status.empty && q_mark && pend_valid && out_free, out_valid && out_last && !pend_valid, "run end did not release the held word")

endmodule

`default_nettype wire

// ===== rtl/core/utf8_sentence_chunk_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_sentence_chunk_splitter_unit
// Splits a UTF-8 byte stream into trimmed sentence chunks given as offsets.
// ----------------------------------------------------------------------------
// Text enters one byte per word on the s_axis channel; s_axis_tlast marks the
// final byte of a text, which flushes the open chunk and restarts offsets.
// Each m_axis word carries one chunk as first and end byte offsets, and
// m_axis_tlast is set on the last chunk caused by one input byte.
// The limit register max_chunk_bytes sits at APB address 0.
// A byte is taken in F_IDLE, then the scanner takes character steps in
// F_SCAN, handles a forced cut in F_WALK, F_WALK_WAIT and F_CUT, stepping
// back over continuation bytes, and queues the end of the run in F_END.
// The trimmer reads the store through its own port and steps over leading
// and trailing space bytes of each chunk. The next byte is taken once the
// trimmer has drained the queue for the previous.
// A finished word waits in the output register while m_axis_tready is low; the
// trimmer keeps working until it needs that register again.
// Reset clears all control state and sets the limit to 256; the byte store is
// not cleared and needs no pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_sentence_chunk_splitter_unit #(
  parameter int CHUNK_STORE_DEPTH = u8cs_pkg::STORE_DEPTH_DEF,
  parameter int OFFSET_WIDTH      = u8cs_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input stream.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  wire logic                           s_axis_tlast,   // end_of_text
  // Output stream.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [2*u8cs_pkg::OUT_W-1:0]        m_axis_tdata,   // [31:0] chunk_first,
                                                              // [63:32] chunk_end
  output logic                                m_axis_tlast,   // last_in_run
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [u8cs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import u8cs_pkg::*;

  // Positions are counted in 64 bits and clamped to the offset width on output.
  localparam int AW = $clog2(CHUNK_STORE_DEPTH);
  localparam int PW = POS_W;
  localparam int EW = 1 + 2 * PW + 2 * AW;

  logic [LIMIT_W-1:0] max_chunk_bytes;
  logic               cfg_write;

  q_status_t          q_status;
  logic               q_push, q_pop;
  logic [EW-1:0]      q_push_data, q_pop_data;
  logic               back_idle;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_a_addr, rd_b_addr;
  logic [7:0]         wr_data, rd_a_data, rd_b_data;
  logic [OUT_W-1:0]   out_first, out_end;

  // Register file: one register, word aligned, low address bits ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_CHUNK);
  assign prdata    = (paddr[2] == REG_MAX_CHUNK) ? 32'(max_chunk_bytes) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk_bytes <= LIMIT_DEFAULT;
    end else if (cfg_write) begin
      max_chunk_bytes <= pwdata[LIMIT_W-1:0];
    end
  end

  u8cs_store #(.DEPTH(CHUNK_STORE_DEPTH), .AW(AW)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // A new byte is taken only once the trimmer is idle with an empty queue, so
  // store writes never disturb a chunk that is still being trimmed.
  logic back_state_idle;
  assign back_idle = back_state_idle && q_status.empty;

  u8cs_front #(.DEPTH(CHUNK_STORE_DEPTH), .AW(AW), .PW(PW), .EW(EW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_fin    (s_axis_tlast),
    .limit_reg (max_chunk_bytes),
    .back_idle (back_idle),
    .q_status  (q_status),
    .push      (q_push),
    .push_data (q_push_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_a_addr),
    .rd_data   (rd_a_data)
  );

  u8cs_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  u8cs_back #(.DEPTH(CHUNK_STORE_DEPTH), .AW(AW), .PW(PW), .OW(OFFSET_WIDTH), .EW(EW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .rd_addr   (rd_b_addr),
    .rd_data   (rd_b_data),
    .idle      (back_state_idle),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_first (out_first),
    .out_end   (out_end),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_end, out_first};

endmodule

`default_nettype wire
